FILE: src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/mes_pkg.sv
// Package: types, constants and codes of the MIDI event scheduler
package mes_pkg;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned TEMPO_W = 24;
   localparam int unsigned TPQ_W   = 15;
   localparam int unsigned CLK_W   = 64;
   // dt * tempo + remainder fits in 57 bits
   localparam int unsigned NUM_W   = TICK_W + TEMPO_W + 1;

   localparam logic [TPQ_W-1:0]   TPQ_RESET     = 15'd480;
   localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 24'd500000;

   // request operations
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STEP   = 2'd1;
   localparam logic [1:0] OP_REWIND = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   // response commands
   localparam logic [2:0] CMD_OFF     = 3'd0;
   localparam logic [2:0] CMD_ON      = 3'd1;
   localparam logic [2:0] CMD_CONTROL = 3'd2;
   localparam logic [2:0] CMD_PROGRAM = 3'd3;
   localparam logic [2:0] CMD_BEND    = 3'd4;
   localparam logic [2:0] CMD_TEMPO   = 3'd5;
   localparam logic [2:0] CMD_IGNORED = 3'd6;
   localparam logic [2:0] CMD_ALL_OFF = 3'd7;

   // status high nibbles
   localparam logic [3:0] ST_OFF     = 4'h8;
   localparam logic [3:0] ST_ON      = 4'h9;
   localparam logic [3:0] ST_CONTROL = 4'hB;
   localparam logic [3:0] ST_PROGRAM = 4'hC;
   localparam logic [3:0] ST_BEND    = 4'hE;
   localparam logic [7:0] ST_META    = 8'hFF;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  channel;
      logic [6:0]  key_or_number;
      logic [6:0]  velocity_or_value;
      logic [13:0] bend_amount;
      logic        want_event;
      logic [63:0] song_time_us;
   } rsp_type;
endpackage

FILE: src/mes_muldiv.sv
// Bit-serial multiply (dt * tempo + rem) followed by restoring division by tpq
module mes_muldiv (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mes_pkg::TICK_W-1:0]   dt,
   input  logic [mes_pkg::TEMPO_W-1:0]  tempo,
   input  logic [mes_pkg::TPQ_W-1:0]    rem_in,
   input  logic [mes_pkg::TPQ_W-1:0]    divisor,
   output logic                         done,
   output logic [mes_pkg::NUM_W-1:0]    quotient,
   output logic [mes_pkg::TPQ_W-1:0]    remainder
);
   import mes_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_ADD  = 2'd2;
   localparam logic [1:0] PH_DIV  = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic [5:0]         count_ff, count_in;
   logic [NUM_W-1:0]   acc_ff, acc_in;
   logic [TEMPO_W-1:0] mult_ff, mult_in;
   logic [TICK_W-1:0]  dt_ff, dt_in;
   logic [TPQ_W-1:0]   rem_ff, rem_in_r;
   logic [TPQ_W-1:0]   div_ff, div_in;
   logic [TPQ_W-1:0]   part_ff, part_in;
   logic               done_ff, done_in;
   logic [TPQ_W:0]     trial;
   logic               fits;

   // one division step: bring down the next numerator bit
   assign trial = {part_ff, acc_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      mult_in  = mult_ff;
      dt_in    = dt_ff;
      rem_in_r = rem_ff;
      div_in   = div_ff;
      part_in  = part_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_MUL;
               count_in = 6'(TEMPO_W - 1);
               acc_in   = '0;
               mult_in  = tempo;
               dt_in    = dt;
               rem_in_r = rem_in;
               div_in   = divisor;
            end
         end
         PH_MUL: begin
            // shift-add, tempo MSB first
            acc_in  = {acc_ff[NUM_W-2:0], 1'b0} +
                      (mult_ff[TEMPO_W-1] ? NUM_W'(dt_ff) : '0);
            mult_in = {mult_ff[TEMPO_W-2:0], 1'b0};
            if (count_ff == '0) phase_in = PH_ADD;
            else count_in = count_ff - 6'd1;
         end
         PH_ADD: begin
            acc_in   = acc_ff + NUM_W'(rem_ff);
            part_in  = '0;
            count_in = 6'(NUM_W - 1);
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            part_in = fits ? TPQ_W'(trial - {1'b0, div_ff}) : trial[TPQ_W-1:0];
            acc_in  = {acc_ff[NUM_W-2:0], fits};
            if (count_ff == '0) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else begin
               count_in = count_ff - 6'd1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      count_ff <= count_in;
      acc_ff   <= acc_in;
      mult_ff  <= mult_in;
      dt_ff    <= dt_in;
      rem_ff   <= rem_in_r;
      div_ff   <= div_in;
      part_ff  <= part_in;
   end

   assign done      = done_ff;
   assign quotient  = acc_ff;
   assign remainder = part_ff;
endmodule

FILE: src/midi_event_scheduler.sv
// Top level: MIDI event scheduler with serial tick-to-microsecond conversion
//
//  channel  | handshake            | carries
//  req_     | req_valid/req_ready  | operation, tick, status, data, tempo, elapsed
//  rsp_     | rsp_valid/rsp_ready  | command, channel, data, bend, want, song time
//  csr_     | csr_write_enable     | ticks_per_quarter
//
//  A load runs 24 multiply steps, one remainder add and 57 division steps in
//  the shared serial mul/div unit, then the due-time add, compare and, with a
//  dispatch, output load. A step adds elapsed time, compares and, with a
//  dispatch, loads the output; an end loads it, a rewind acts on acceptance.
//  Synchronous reset restores all song state and ticks_per_quarter = 480.
//  A finished response waits in the output register; a stalled response
//  holds the block only when a second response is ready behind it.
module midi_event_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [31:0]                   req_event_tick,
   input  logic [7:0]                    req_status_byte,
   input  logic [6:0]                    req_data_first,
   input  logic [6:0]                    req_data_second,
   input  logic [23:0]                   req_tempo_value,
   input  logic [31:0]                   req_elapsed_us,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_command,
   output logic [3:0]                    rsp_channel,
   output logic [6:0]                    rsp_key_or_number,
   output logic [6:0]                    rsp_velocity_or_value,
   output logic [13:0]                   rsp_bend_amount,
   output logic                          rsp_want_event,
   output logic [63:0]                   rsp_song_time_us,
   input  logic                          csr_write_enable,
   input  logic [14:0]                   csr_write_data
);
   import mes_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MD    = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_OUT   = 3'd3;

   logic [2:0]         state_ff, state_in;
   logic [TPQ_W-1:0]   tpq_ff;
   logic [CLK_W-1:0]   clock_ff, clock_in;
   logic [CLK_W-1:0]   due_ff, due_in;
   logic [TPQ_W-1:0]   rem_ff, rem_in;
   logic [TICK_W-1:0]  prev_ff, prev_in;
   logic [TEMPO_W-1:0] tempo_ff, tempo_in;
   logic [7:0]         p_status_ff, p_status_in;
   logic [6:0]         p_first_ff, p_first_in;
   logic [6:0]         p_second_ff, p_second_in;
   logic [TEMPO_W-1:0] p_tempo_ff, p_tempo_in;
   logic               p_valid_ff, p_valid_in;
   logic               ended_ff, ended_in;
   rsp_type            stage_ff, stage_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               md_start;
   logic [TICK_W-1:0]  md_dt;
   logic [TPQ_W-1:0]   md_div;
   logic               md_done;
   logic [NUM_W-1:0]   md_quot;
   logic [TPQ_W-1:0]   md_rem;
   logic               req_fire;
   rsp_type            disp;
   logic [3:0]         hi_nib;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign md_dt     = req_event_tick - prev_ff;
   assign md_div    = (tpq_ff == '0) ? TPQ_W'(1) : tpq_ff;
   assign md_start  = req_fire && (req_operation == OP_LOAD) && !p_valid_ff && !ended_ff;

   mes_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .start     (md_start),
      .dt        (md_dt),
      .tempo     (tempo_ff),
      .rem_in    (rem_ff),
      .divisor   (md_div),
      .done      (md_done),
      .quotient  (md_quot),
      .remainder (md_rem)
   );

   // classify the pending event
   assign hi_nib = p_status_ff[7:4];
   always_comb begin
      disp = '0;
      disp.command      = CMD_IGNORED;
      disp.want_event   = !ended_ff;
      disp.song_time_us = clock_ff;
      priority if (hi_nib == ST_OFF || hi_nib == ST_ON || hi_nib == ST_CONTROL) begin
         disp.command           = (hi_nib == ST_OFF) ? CMD_OFF :
                                  (hi_nib == ST_ON) ? CMD_ON : CMD_CONTROL;
         disp.channel           = p_status_ff[3:0];
         disp.key_or_number     = p_first_ff;
         disp.velocity_or_value = p_second_ff;
      end else if (hi_nib == ST_PROGRAM) begin
         disp.command       = CMD_PROGRAM;
         disp.channel       = p_status_ff[3:0];
         disp.key_or_number = p_first_ff;
      end else if (hi_nib == ST_BEND) begin
         disp.command     = CMD_BEND;
         disp.channel     = p_status_ff[3:0];
         disp.bend_amount = {p_second_ff, p_first_ff};
      end else if (p_status_ff == ST_META) begin
         disp.command = CMD_TEMPO;
      end else begin
         disp.command = CMD_IGNORED;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clock_in     = clock_ff;
      due_in       = due_ff;
      rem_in       = rem_ff;
      prev_in      = prev_ff;
      tempo_in     = tempo_ff;
      p_status_in  = p_status_ff;
      p_first_in   = p_first_ff;
      p_second_in  = p_second_ff;
      p_tempo_in   = p_tempo_ff;
      p_valid_in   = p_valid_ff;
      ended_in     = ended_ff;
      stage_in     = stage_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_operation)
                  OP_LOAD: begin
                     if (md_start) begin
                        prev_in     = req_event_tick;
                        p_status_in = req_status_byte;
                        p_first_in  = req_data_first;
                        p_second_in = req_data_second;
                        p_tempo_in  = req_tempo_value;
                        state_in    = S_MD;
                     end
                  end
                  OP_STEP: begin
                     if (!ended_ff) begin
                        clock_in = clock_ff + CLK_W'(req_elapsed_us);
                        state_in = S_CHECK;
                     end
                  end
                  OP_REWIND: begin
                     clock_in   = '0;
                     due_in     = '0;
                     rem_in     = '0;
                     prev_in    = '0;
                     tempo_in   = TEMPO_DEFAULT;
                     p_valid_in = 1'b0;
                     ended_in   = 1'b0;
                  end
                  OP_END: begin
                     if (!p_valid_ff && !ended_ff) begin
                        ended_in              = 1'b1;
                        stage_in              = '0;
                        stage_in.command      = CMD_ALL_OFF;
                        stage_in.song_time_us = clock_ff;
                        state_in              = S_OUT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MD: begin
            if (md_done) begin
               due_in     = due_ff + CLK_W'(md_quot);
               rem_in     = md_rem;
               p_valid_in = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (p_valid_ff && (due_ff <= clock_ff)) begin
               stage_in   = disp;
               p_valid_in = 1'b0;
               if (p_status_ff == ST_META) tempo_in = p_tempo_ff;
               state_in   = S_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = stage_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tpq_ff       <= TPQ_RESET;
         clock_ff     <= '0;
         due_ff       <= '0;
         rem_ff       <= '0;
         prev_ff      <= '0;
         tempo_ff     <= TEMPO_DEFAULT;
         p_valid_ff   <= 1'b0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) tpq_ff <= csr_write_data;
         clock_ff     <= clock_in;
         due_ff       <= due_in;
         rem_ff       <= rem_in;
         prev_ff      <= prev_in;
         tempo_ff     <= tempo_in;
         p_valid_ff   <= p_valid_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_status_ff <= p_status_in;
      p_first_ff  <= p_first_in;
      p_second_ff <= p_second_in;
      p_tempo_ff  <= p_tempo_in;
      stage_ff    <= stage_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_command           = rsp_ff.command;
   assign rsp_channel           = rsp_ff.channel;
   assign rsp_key_or_number     = rsp_ff.key_or_number;
   assign rsp_velocity_or_value = rsp_ff.velocity_or_value;
   assign rsp_bend_amount       = rsp_ff.bend_amount;
   assign rsp_want_event        = rsp_ff.want_event;
   assign rsp_song_time_us      = rsp_ff.song_time_us;
endmodule

FILE: src/mes_checker.sv
// Port-level checker for the MIDI event scheduler, bound to the top level
`include "assert_macros.svh"

module mes_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_command,
   input logic [13:0] rsp_bend_amount,
   input logic        rsp_want_event,
   input logic [63:0] rsp_song_time_us
);
   import mes_pkg::*;

   // a stalled response holds its song time
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_song_time_us))
   // end of song never asks for another event
   `ASSERT_SAME(a_end_no_want, clock, reset, rsp_valid && rsp_command == CMD_ALL_OFF, !rsp_want_event)
   // bend field is zero outside bend commands
   `ASSERT_SAME(a_bend_only, clock, reset, rsp_valid && rsp_command != CMD_BEND, rsp_bend_amount == '0)
   // a stalled response stays valid
   `ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind midi_event_scheduler mes_checker u_mes_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_command      (rsp_command),
   .rsp_bend_amount  (rsp_bend_amount),
   .rsp_want_event   (rsp_want_event),
   .rsp_song_time_us (rsp_song_time_us)
);
